/* rtl/core/assert_macros.svh */
// assertion macros shared by the refresh sequencer rtl
// no dependencies; expands to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, pre, post)

`define ASSERT_NEXT(lbl, clk, rst, pre, post)

`endif

`endif

/* rtl/core/fbrs_pkg.sv */
// shared types and constants of the page framebuffer refresh sequencer
// no dependencies
package fbrs_pkg;

  localparam int DEFAULT_PANEL_WIDTH = 128;
  localparam int DEFAULT_PAGE_COUNT  = 8;

  localparam logic [7:0] COLUMN_OFFSET_RESET = 8'h02;

  localparam logic [7:0] CTRL_COMMAND  = 8'h00;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [3:0] NIBBLE_MASK   = 4'hF;

  localparam int HEADER_LEN = 7;

  // position of each byte within the page header
  localparam logic [2:0] HDR_CTRL_PAGE = 3'd0;
  localparam logic [2:0] HDR_PAGE_CMD  = 3'd1;
  localparam logic [2:0] HDR_CTRL_LOW  = 3'd2;
  localparam logic [2:0] HDR_LOW_CMD   = 3'd3;
  localparam logic [2:0] HDR_CTRL_HIGH = 3'd4;
  localparam logic [2:0] HDR_HIGH_CMD  = 3'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_EMIT  = 2'd2,
    OP_ABORT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] page;
    logic [7:0] col;
    logic [2:0] bit_sel;
    logic       pixel_on;
  } fbrs_cmd_t;

endpackage

/* rtl/core/fbrs_if.sv */
// valid/ready channels of the refresh sequencer: items, results, configuration
// no dependencies
interface fbrs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] x_pos;
  logic [6:0] y_pos;
  logic       pixel_on;

  modport source(output valid, operation, x_pos, y_pos, pixel_on, input ready);
  modport sink(input valid, operation, x_pos, y_pos, pixel_on, output ready);
endinterface

interface fbrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       transfer_start;
  logic       transfer_end;
  logic       refresh_end;

  modport source(output valid, out_byte, transfer_start, transfer_end, refresh_end,
                 input ready);
  modport sink(input valid, out_byte, transfer_start, transfer_end, refresh_end,
               output ready);
endinterface

interface fbrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] column_offset;

  modport source(output valid, column_offset, input ready);
  modport sink(input valid, column_offset, output ready);
endinterface

/* rtl/core/fbrs_front.sv */
// front end: accepts item beats, drops off-panel draws, builds queue commands
// depends on fbrs_pkg and fbrs_in_if
module fbrs_front #(
  parameter int PANEL_WIDTH = fbrs_pkg::DEFAULT_PANEL_WIDTH,
  parameter int PAGE_COUNT  = fbrs_pkg::DEFAULT_PAGE_COUNT
) (
  fbrs_in_if.sink              item,
  input  logic                 q_full,
  output logic                 q_push,
  output fbrs_pkg::fbrs_cmd_t  q_entry
);
  import fbrs_pkg::*;

  logic on_panel;
  logic drop;
  op_t  op;

  assign op       = op_t'(item.operation);
  assign on_panel = ({1'b0, item.x_pos} < 9'(PANEL_WIDTH)) &&
                    ({1'b0, item.y_pos} < 8'(PAGE_COUNT * 8));
  assign drop     = (op == OP_DRAW) && !on_panel;

  assign item.ready = !q_full;
  assign q_push     = item.valid && !q_full && !drop;

  always_comb begin
    q_entry.op       = op;
    q_entry.page     = item.y_pos[6:3];
    q_entry.col      = item.x_pos;
    q_entry.bit_sel  = item.y_pos[2:0];
    q_entry.pixel_on = item.pixel_on;
  end

endmodule

/* rtl/core/fbrs_queue.sv */
// short command queue between front and back end
// depends on fbrs_pkg
module fbrs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fbrs_pkg::fbrs_cmd_t  push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output fbrs_pkg::fbrs_cmd_t  head
);
  import fbrs_pkg::*;

  fbrs_cmd_t              entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/fbrs_back.sv */
// back end: frame store, pixel read-modify-write, clear sweep, refresh sequencer
// depends on fbrs_pkg, fbrs_out_if and assert_macros.svh
`include "assert_macros.svh"

module fbrs_back #(
  parameter int PANEL_WIDTH = fbrs_pkg::DEFAULT_PANEL_WIDTH,
  parameter int PAGE_COUNT  = fbrs_pkg::DEFAULT_PAGE_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           column_offset,
  input  logic                 q_valid,
  input  fbrs_pkg::fbrs_cmd_t  q_head,
  output logic                 q_pop,
  fbrs_out_if.source           result
);
  import fbrs_pkg::*;

  localparam int COL_W  = $clog2(PANEL_WIDTH);
  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ADDR_W = PAGE_W + COL_W;
  localparam int DEPTH  = 2 ** ADDR_W;

  back_state_t state;
  back_state_t state_next;

  logic [7:0]        mem [DEPTH];
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  logic [ADDR_W-1:0] sweep_cnt;
  logic [ADDR_W-1:0] draw_addr;
  logic [ADDR_W-1:0] head_addr;
  logic [ADDR_W-1:0] seq_addr;
  logic [2:0]        draw_bit;
  logic              draw_on;
  logic [7:0]        draw_mask;

  logic [PAGE_W-1:0] page_counter;
  logic [COL_W-1:0]  byte_counter;
  logic              data_phase;
  logic              col_last;
  logic              page_last;
  logic              hdr_last;

  logic [7:0] hdr_byte;
  logic       hdr_start;
  logic       hdr_end;

  logic       pend_data;
  logic [7:0] pend_byte;
  logic       pend_start;
  logic       pend_end;
  logic       pend_last;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_start;
  logic       out_end;
  logic       out_last;
  logic       load_out;
  logic       take_emit;
  logic       take_abort;
  logic       take_draw;

  assign head_addr = {q_head.page[PAGE_W-1:0], q_head.col[COL_W-1:0]};
  assign seq_addr  = {page_counter, byte_counter};
  assign col_last  = (byte_counter == COL_W'(PANEL_WIDTH - 1));
  assign page_last = (page_counter == PAGE_W'(PAGE_COUNT - 1));
  assign hdr_last  = (byte_counter == COL_W'(HEADER_LEN - 1));
  assign draw_mask = 8'h01 << draw_bit;

  always_comb begin
    hdr_byte  = CTRL_DATA;
    hdr_start = 1'b0;
    hdr_end   = 1'b0;
    unique case (byte_counter[2:0]) inside
      HDR_CTRL_PAGE, HDR_CTRL_LOW, HDR_CTRL_HIGH: begin
        hdr_byte  = CTRL_COMMAND;
        hdr_start = 1'b1;
      end
      HDR_PAGE_CMD: begin
        hdr_byte = CMD_PAGE_BASE + 8'(page_counter);
        hdr_end  = 1'b1;
      end
      HDR_LOW_CMD: begin
        hdr_byte = {4'h0, column_offset[3:0] & NIBBLE_MASK};
        hdr_end  = 1'b1;
      end
      HDR_HIGH_CMD: begin
        hdr_byte = CMD_COL_HIGH | {4'h0, column_offset[7:4] & NIBBLE_MASK};
        hdr_end  = 1'b1;
      end
      default: begin
        hdr_byte  = CTRL_DATA;
        hdr_start = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = seq_addr;
    wr_en      = 1'b0;
    wr_addr    = draw_addr;
    wr_data    = draw_on ? (rd_data | draw_mask) : (rd_data & ~draw_mask);
    load_out   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep_cnt;
        wr_data = '0;
        if (sweep_cnt == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            OP_DRAW: begin
              rd_en      = 1'b1;
              rd_addr    = head_addr;
              state_next = ST_DRAW;
            end
            OP_CLEAR: state_next = ST_CLEAR;
            OP_EMIT: begin
              rd_en      = 1'b1;
              state_next = ST_EMIT;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DRAW: begin
        wr_en      = 1'b1;
        state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign take_emit  = q_pop && (q_head.op == OP_EMIT);
  assign take_abort = q_pop && (q_head.op == OP_ABORT);
  assign take_draw  = q_pop && (q_head.op == OP_DRAW);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_draw) begin
      draw_addr <= head_addr;
      draw_bit  <= q_head.bit_sel;
      draw_on   <= q_head.pixel_on;
    end
  end

  // sequencer position
  always_ff @(posedge clk) begin
    if (rst || take_abort) begin
      page_counter <= '0;
      byte_counter <= '0;
      data_phase   <= 1'b0;
    end else if (take_emit) begin
      if (!data_phase) begin
        if (hdr_last) begin
          byte_counter <= '0;
          data_phase   <= 1'b1;
        end else begin
          byte_counter <= byte_counter + 1'b1;
        end
      end else if (col_last) begin
        byte_counter <= '0;
        data_phase   <= 1'b0;
        page_counter <= page_last ? '0 : page_counter + 1'b1;
      end else begin
        byte_counter <= byte_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_emit) begin
      pend_data  <= data_phase;
      pend_byte  <= hdr_byte;
      pend_start <= !data_phase && hdr_start;
      pend_end   <= data_phase ? col_last : hdr_end;
      pend_last  <= data_phase && col_last && page_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte  <= pend_data ? rd_data : pend_byte;
      out_start <= pend_start;
      out_end   <= pend_end;
      out_last  <= pend_last;
    end
  end

  assign result.valid          = out_valid;
  assign result.out_byte       = out_byte;
  assign result.transfer_start = out_start;
  assign result.transfer_end   = out_end;
  assign result.refresh_end    = out_last;

  `ASSERT_IMPLY(a_no_pop_in_sweep, clk, rst, state == ST_CLEAR, !q_pop)
  `ASSERT_IMPLY(a_write_source, clk, rst, wr_en, state == ST_CLEAR || state == ST_DRAW)
  `ASSERT_NEXT(a_emit_loads, clk, rst, load_out, out_valid)
  `ASSERT_IMPLY(a_page_range, clk, rst, 1'b1, 32'(page_counter) < PAGE_COUNT)
  `ASSERT_IMPLY(a_last_closes, clk, rst, out_valid && out_last, out_end && !out_start)

endmodule

/* rtl/core/page_framebuffer_refresh_sequencer.sv */
// page framebuffer refresh sequencer: in the back end a draw is a store read then a write,
// an emit a store read then an output load that waits while the output holds an untaken
// byte, an abort a pop alone; a clear walks all 2**(PAGE_W + COL_W) store entries (1024 at
// default size) at one entry a cycle, set by the single store write port; reset clears the
// store by the same sweep while the queue holds up to 2 items; configuration beats are taken
// at any time; an emit item passes the queue, the store read and pending byte registers and
// the output register; depends on fbrs_pkg, fbrs_if, fbrs_front, fbrs_queue and fbrs_back
module page_framebuffer_refresh_sequencer #(
  parameter int PANEL_WIDTH = fbrs_pkg::DEFAULT_PANEL_WIDTH,
  parameter int PAGE_COUNT  = fbrs_pkg::DEFAULT_PAGE_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  fbrs_in_if.sink     item,
  fbrs_out_if.source  result,
  fbrs_cfg_if.sink    cfg
);
  import fbrs_pkg::*;

  logic [7:0] column_offset;
  logic       q_full;
  logic       q_push;
  fbrs_cmd_t  q_entry;
  logic       q_pop;
  logic       q_valid;
  fbrs_cmd_t  q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= COLUMN_OFFSET_RESET;
    end else if (cfg.valid) begin
      column_offset <= cfg.column_offset;
    end
  end

  fbrs_front #(
    .PANEL_WIDTH(PANEL_WIDTH),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_front (
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_entry(q_entry)
  );

  fbrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  fbrs_back #(
    .PANEL_WIDTH(PANEL_WIDTH),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .column_offset(column_offset),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result       (result)
  );

endmodule

/* verif/tb_top.sv */
// self-checking testbench of page_framebuffer_refresh_sequencer: draw, clear, emit and abort
// items checked byte by byte against a behavioral refresh stream model in a small scoreboard
// depends on fbrs_pkg, fbrs_if and the sequencer rtl
module tb_top;
  import fbrs_pkg::*;

  localparam int PANEL_WIDTH     = DEFAULT_PANEL_WIDTH;
  localparam int PAGE_COUNT      = DEFAULT_PAGE_COUNT;
  localparam int STORE_WORDS     = PANEL_WIDTH * PAGE_COUNT;
  localparam int SETTLE_CYCLES   = 3 * (STORE_WORDS + 64);
  localparam int ITEMS_PER_PHASE = 260;
  localparam int PHASES          = 6;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 1_000_000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       transfer_start;
    logic       transfer_end;
    logic       refresh_end;
  } stream_byte_t;

  class refresh_stream_checker;
    bit [7:0]     frame [STORE_WORDS];
    int           page;
    int           pos;
    bit           in_columns;
    logic [7:0]   col_offset;
    stream_byte_t pending [$];
    int           errors;
    int           checked;
    int           refreshes;
    int           op_count [4];

    function new();
      foreach (frame[i]) frame[i] = '0;
      page = 0;
      pos = 0;
      in_columns = 1'b0;
      col_offset = COLUMN_OFFSET_RESET;
      errors = 0;
      checked = 0;
      refreshes = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function stream_byte_t next_stream_byte();
      stream_byte_t b;
      b = '0;
      if (!in_columns) begin
        case (3'(pos))
          HDR_CTRL_PAGE, HDR_CTRL_LOW, HDR_CTRL_HIGH: begin
            b.out_byte = CTRL_COMMAND;
            b.transfer_start = 1'b1;
          end
          HDR_PAGE_CMD: begin
            b.out_byte = CMD_PAGE_BASE + 8'(page);
            b.transfer_end = 1'b1;
          end
          HDR_LOW_CMD: begin
            b.out_byte = {4'h0, col_offset[3:0] & NIBBLE_MASK};
            b.transfer_end = 1'b1;
          end
          HDR_HIGH_CMD: begin
            b.out_byte = CMD_COL_HIGH | {4'h0, col_offset[7:4] & NIBBLE_MASK};
            b.transfer_end = 1'b1;
          end
          default: begin
            b.out_byte = CTRL_DATA;
            b.transfer_start = 1'b1;
          end
        endcase
        pos++;
        if (pos >= HEADER_LEN) begin
          pos = 0;
          in_columns = 1'b1;
        end
      end else begin
        // column bytes are read from the store when their emit item is accepted
        b.out_byte = frame[page * PANEL_WIDTH + pos];
        if (pos == PANEL_WIDTH - 1) begin
          b.transfer_end = 1'b1;
          pos = 0;
          in_columns = 1'b0;
          if (page + 1 >= PAGE_COUNT) begin
            b.refresh_end = 1'b1;
            page = 0;
            refreshes++;
          end else begin
            page++;
          end
        end else begin
          pos++;
        end
      end
      return b;
    endfunction

    function void note_item(op_t op, logic [7:0] x, logic [6:0] y, logic on);
      int idx;
      op_count[op]++;
      case (op)
        OP_DRAW: begin
          if (int'(x) < PANEL_WIDTH && int'(y) < PAGE_COUNT * 8) begin
            idx = int'(y >> 3) * PANEL_WIDTH + int'(x);
            frame[idx][y[2:0]] = on;
          end
        end
        OP_CLEAR: foreach (frame[i]) frame[i] = '0;
        OP_EMIT:  pending.push_back(next_stream_byte());
        default: begin
          page = 0;
          pos = 0;
          in_columns = 1'b0;
        end
      endcase
    endfunction

    function void check_result(stream_byte_t got);
      stream_byte_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: out_byte %02h", got.out_byte);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.transfer_start !== want.transfer_start) begin
        $error("transfer_start: expected %0b, got %0b", want.transfer_start,
               got.transfer_start);
        errors++;
      end
      if (got.transfer_end !== want.transfer_end) begin
        $error("transfer_end: expected %0b, got %0b", want.transfer_end, got.transfer_end);
        errors++;
      end
      if (got.refresh_end !== want.refresh_end) begin
        $error("refresh_end: expected %0b, got %0b", want.refresh_end, got.refresh_end);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  fbrs_in_if  in_ch ();
  fbrs_out_if out_ch ();
  fbrs_cfg_if cfg_ch ();

  page_framebuffer_refresh_sequencer #(
    .PANEL_WIDTH(PANEL_WIDTH),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (in_ch),
    .result(out_ch),
    .cfg   (cfg_ch)
  );

  refresh_stream_checker sb;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int offsets_written;
  int cycles;

  always #4 clk = ~clk;

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls plus the long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    stream_byte_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.out_byte       = out_ch.out_byte;
      got.transfer_start = out_ch.transfer_start;
      got.transfer_end   = out_ch.transfer_end;
      got.refresh_end    = out_ch.refresh_end;
      sb.check_result(got);
    end
  end

  task automatic send_item(input op_t op, input logic [7:0] x, input logic [6:0] y,
                           input logic on);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.x_pos     = x;
    in_ch.y_pos     = y;
    in_ch.pixel_on  = on;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(op, x, y, on);
    @(negedge clk);
  endtask

  task automatic send_random_item();
    int         r;
    op_t        op;
    logic [7:0] x;
    logic [6:0] y;
    r = $urandom_range(99);
    if (r == 0) op = OP_CLEAR;
    else if (r < 4 && sb.refreshes > 0) op = OP_ABORT;
    else if (r < 22) op = OP_DRAW;
    else op = OP_EMIT;
    if (op == OP_DRAW && $urandom_range(9) != 0) begin
      x = 8'($urandom_range(PANEL_WIDTH - 1));
      y = 7'($urandom_range(PAGE_COUNT * 8 - 1));
    end else begin
      x = 8'($urandom_range(255));
      y = 7'($urandom_range(127));
    end
    send_item(op, x, y, 1'($urandom_range(1)));
  endtask

  task automatic write_column_offset(input logic [7:0] value);
    cfg_ch.valid         = 1'b1;
    cfg_ch.column_offset = value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.col_offset = value;
    offsets_written++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // all results in, then room for a trailing clear sweep
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_directed();
    send_item(OP_DRAW, 8'd0, 7'd0, 1'b1);
    send_item(OP_DRAW, 8'd127, 7'd63, 1'b1);
    send_item(OP_DRAW, 8'd255, 7'd127, 1'b1);
    send_item(OP_DRAW, 8'd128, 7'd5, 1'b1);
    send_item(OP_DRAW, 8'd5, 7'd64, 1'b1);
    send_item(OP_DRAW, 8'd3, 7'd7, 1'b1);
    send_item(OP_DRAW, 8'd2, 7'd7, 1'b0);
    repeat (HEADER_LEN) send_item(OP_EMIT, 8'hFF, 7'h7F, 1'b1);
    // draw during refresh, then clear during refresh
    send_item(OP_DRAW, 8'd1, 7'd3, 1'b1);
    repeat (4) send_item(OP_EMIT, 8'd0, 7'd0, 1'b0);
    send_item(OP_CLEAR, 8'd0, 7'd0, 1'b0);
    send_item(OP_EMIT, 8'd0, 7'd0, 1'b0);
    send_item(OP_ABORT, 8'hAA, 7'h55, 1'b0);
    repeat (2) send_item(OP_EMIT, 8'h55, 7'h2A, 1'b1);
  endtask

  initial begin : stimulus
    logic [7:0] offsets [PHASES];
    int         phase;
    int         n;
    sb = new();
    offsets = '{8'h00, 8'hFF, 8'hF0, 8'h0F, 8'h00, 8'h02};
    offsets[4] = 8'($urandom_range(255));
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_left       = 0;
    offsets_written = 0;
    rst                  = 1'b1;
    in_ch.valid          = 1'b0;
    in_ch.operation      = OP_DRAW;
    in_ch.x_pos          = '0;
    in_ch.y_pos          = '0;
    in_ch.pixel_on       = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.column_offset = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      write_column_offset(offsets[phase]);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 0 && n == 40) begin
          // long receiver hold so the queue backs up into the input
          in_ch.valid = 1'b0;
          @(posedge clk);
          hold_left = HOLD_CYCLES;
          @(negedge clk);
        end
        send_random_item();
      end
    end

    wait_idle();
    $display("%0d items: %0d draws, %0d clears, %0d emits, %0d aborts; %0d bytes checked",
             sb.op_count[OP_DRAW] + sb.op_count[OP_CLEAR] + sb.op_count[OP_EMIT]
             + sb.op_count[OP_ABORT], sb.op_count[OP_DRAW], sb.op_count[OP_CLEAR],
             sb.op_count[OP_EMIT], sb.op_count[OP_ABORT], sb.checked);
    $display("%0d full refreshes, %0d column offsets, idle/stall mixes and a long hold",
             sb.refreshes, offsets_written);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
